>>> src/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types and constants for the CPF check digit generator.
// ----------------------------------------------------------------------------
package cpf_pkg;

    // item and sum widths
    localparam int VALUE_W    = 30;
    localparam int DIGIT_W    = 4;
    localparam int SUM1_W     = 9;   // at most 9 * (10 + ... + 2) = 486
    localparam int SUM2_W     = 10;  // at most 9 * (11 + ... + 3) + 18 = 585
    localparam int NUM_DIGITS = 9;
    localparam int WEIGHT_W   = 4;

    // lowest weight of the first sum, used on the least significant digit
    localparam int FIRST_WEIGHT = 2;

    // divide by ten: floor(x * RECIP10 / 2^RECIP10_SHIFT), exact for x < 2^32
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;
    localparam int          QUOT10_W      = VALUE_W - 3;

    // running value and partial sums that travel down the digit stages
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [SUM1_W-1:0]  sum1;
        logic [SUM2_W-1:0]  sum2;
    } digit_bus_t;

endpackage

>>> src/cpf_check_digit_generator.sv
// ----------------------------------------------------------------------------
// cpf_check_digit_generator
// Computes the two mod-11 CPF check digits of a nine-digit base number.
// ----------------------------------------------------------------------------
// channel   | handshake                  | payload
// base      | base_valid / base_stall    | base_number[29:0]
// check     | check_valid / check_stall  | first_check_digit[3:0],
//           |                            | second_check_digit[3:0]
//
// One item per cycle unless check_stall holds the pipeline; the stages are nine digit stages (one
// divide-by-ten multiplier each), then mod 11 of the first sum, the first
// digit folded into the second sum, mod 11 of that sum, and the output register.
// Reset clears only the valid bits. Each stage holds while the one after it
// is full and held, so bubbles close up and a stall loses or repeats nothing.
// ----------------------------------------------------------------------------
module cpf_check_digit_generator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          base_valid,
    output logic                          base_stall,
    input  logic [cpf_pkg::VALUE_W-1:0]   base_number,
    output logic                          check_valid,
    input  logic                          check_stall,
    output logic [cpf_pkg::DIGIT_W-1:0]   first_check_digit,
    output logic [cpf_pkg::DIGIT_W-1:0]   second_check_digit
);
    import cpf_pkg::*;

    // remainder of a small sum by eleven
    function automatic logic [DIGIT_W-1:0] mod11(input logic [SUM2_W-1:0] s);
        logic [SUM2_W+12:0] prod;
        logic [6:0]         q;
        logic [SUM2_W-1:0]  r;
        prod = {13'b0, s} * (SUM2_W+13)'(5958);
        q    = prod[22:16];
        r    = s - SUM2_W'({q, 3'b000} + {2'b00, q, 1'b0} + {3'b000, q});
        return r[DIGIT_W-1:0];
    endfunction

    // check digit from a remainder
    function automatic logic [DIGIT_W-1:0] digit_rule(input logic [DIGIT_W-1:0] r);
        return (r < DIGIT_W'(2)) ? '0 : DIGIT_W'(11) - r;
    endfunction

    digit_bus_t            bus_in   [0:NUM_DIGITS-1];
    digit_bus_t            bus_out  [0:NUM_DIGITS-1];
    logic [NUM_DIGITS-1:0] dvalid;
    logic [NUM_DIGITS-1:0] dready;

    logic                  a_valid_reg;
    logic [DIGIT_W-1:0]    a_rem1_reg;
    logic [SUM2_W-1:0]     a_sum2_reg;
    logic                  b_valid_reg;
    logic [DIGIT_W-1:0]    b_c1_reg;
    logic [SUM2_W-1:0]     b_sum2_reg;
    logic [DIGIT_W-1:0]    b_c1_next;
    logic                  c_valid_reg;
    logic [DIGIT_W-1:0]    c_c1_reg;
    logic [DIGIT_W-1:0]    c_rem2_reg;
    logic                  out_valid_reg;
    logic [DIGIT_W-1:0]    out_c1_reg;
    logic [DIGIT_W-1:0]    out_c2_reg;

    logic                  out_ready;
    logic                  c_ready;
    logic                  b_ready;
    logic                  a_ready;

    // load enables: a stage loads when empty or when the next one loads
    assign out_ready = !out_valid_reg || !check_stall;
    assign c_ready   = !c_valid_reg || out_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;

    always_comb
    begin
        dready[NUM_DIGITS-1] = !dvalid[NUM_DIGITS-1] || a_ready;
        for (int i = NUM_DIGITS - 2; i >= 0; i--)
        begin
            dready[i] = !dvalid[i] || dready[i+1];
        end
    end

    assign base_stall = !dready[0];

    // digit stages, least significant digit first
    always_comb
    begin
        bus_in[0].value = base_number;
        bus_in[0].sum1  = '0;
        bus_in[0].sum2  = '0;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            bus_in[i] = bus_out[i-1];
        end
    end

    for (genvar g = 0; g < NUM_DIGITS; g++)
    begin : g_digit
        cpf_digit_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (dready[g]),
            .valid_in  ((g == 0) ? base_valid : dvalid[(g == 0) ? 0 : g-1]),
            .bus_in    (bus_in[g]),
            .weight    (WEIGHT_W'(FIRST_WEIGHT + g)),
            .valid_out (dvalid[g]),
            .bus_out   (bus_out[g])
        );
    end

    // first check digit
    assign b_c1_next = digit_rule(a_rem1_reg);

    // tail valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= dvalid[NUM_DIGITS-1];
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    // tail payload: mod 11, fold first digit in, mod 11, output
    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_rem1_reg <= mod11(SUM2_W'(bus_out[NUM_DIGITS-1].sum1));
            a_sum2_reg <= bus_out[NUM_DIGITS-1].sum2;
        end
        if (b_ready)
        begin
            b_c1_reg   <= b_c1_next;
            b_sum2_reg <= a_sum2_reg + SUM2_W'({b_c1_next, 1'b0});
        end
        if (c_ready)
        begin
            c_c1_reg   <= b_c1_reg;
            c_rem2_reg <= mod11(b_sum2_reg);
        end
        if (out_ready)
        begin
            out_c1_reg <= c_c1_reg;
            out_c2_reg <= digit_rule(c_rem2_reg);
        end
    end

    assign check_valid        = out_valid_reg;
    assign first_check_digit  = out_c1_reg;
    assign second_check_digit = out_c2_reg;

endmodule

>>> src/cpf_digit_stage.sv
// ----------------------------------------------------------------------------
// cpf_digit_stage
// One pipeline stage: peels the lowest decimal digit off the running value
// and adds its weighted share to both check sums.
// ----------------------------------------------------------------------------
module cpf_digit_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           valid_in,
    input  cpf_pkg::digit_bus_t            bus_in,
    input  logic [cpf_pkg::WEIGHT_W-1:0]   weight,
    output logic                           valid_out,
    output cpf_pkg::digit_bus_t            bus_out
);
    import cpf_pkg::*;

    logic [VALUE_W+31:0]   prod;
    logic [QUOT10_W-1:0]   quot;
    logic [VALUE_W-1:0]    rem_full;
    logic [DIGIT_W-1:0]    digit;
    logic [WEIGHT_W-1:0]   weight2;
    logic                  valid_reg;
    digit_bus_t            bus_reg;
    digit_bus_t            bus_next;

    // divide by ten through the reciprocal
    always_comb
    begin
        prod     = {32'b0, bus_in.value} * {{VALUE_W{1'b0}}, RECIP10};
        quot     = prod[RECIP10_SHIFT+QUOT10_W-1:RECIP10_SHIFT];
        rem_full = bus_in.value - ({quot, 3'b000} + {2'b00, quot, 1'b0});
        digit    = rem_full[DIGIT_W-1:0];
        weight2  = weight + WEIGHT_W'(1);
    end

    // accumulate weighted digit into both sums
    always_comb
    begin
        bus_next.value = {3'b000, quot};
        bus_next.sum1  = bus_in.sum1 + SUM1_W'(digit) * SUM1_W'(weight);
        bus_next.sum2  = bus_in.sum2 + SUM2_W'(digit) * SUM2_W'(weight2);
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bus_reg <= bus_next;
        end
    end

    assign valid_out = valid_reg;
    assign bus_out   = bus_reg;

endmodule
